// ===== src/flexfit_pkg.sv =====
`timescale 1ns / 1ps
// Package of shared types, constants and helper functions for the flexpage alignment fitter.
package flexfit_pkg;

    localparam int ADDR_W         = 64;
    localparam int ALIGN_W        = 7;
    localparam int MIN_PAGE_SHIFT = 12;
    localparam int BYTE_W         = 8;
    localparam int BYTE_CNT       = ADDR_W / BYTE_W;
    localparam int BYTE_IDX_W     = $clog2(BYTE_CNT);
    localparam int BIT_IDX_W      = $clog2(BYTE_W);

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [ALIGN_W-1:0]    align_t;
    typedef logic [BYTE_IDX_W-1:0] byte_idx_t;
    typedef logic [BIT_IDX_W-1:0]  bit_idx_t;

    typedef struct packed {
        addr_t  fault_address;
        addr_t  remote_start;
        addr_t  local_start;
        addr_t  local_end;
        align_t max_align;
    } in_item_t;

    typedef struct packed {
        align_t map_align;
        addr_t  local_map_base;
        addr_t  remote_map_base;
    } out_item_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_LE
    } alu_op_t;

    typedef enum logic [2:0] {
        SEL_OFFSET,
        SEL_LBASE,
        SEL_RBASE,
        SEL_FIT_LO,
        SEL_FIT_HI
    } opnd_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OFFSET,
        ST_LBASE,
        ST_RBASE,
        ST_TZ_BYTE,
        ST_TZ_BIT,
        ST_FIT_LO,
        ST_FIT_HI,
        ST_CLAMP,
        ST_OUTPUT
    } fsm_state_t;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        alu_op_t   alu_op;
        opnd_sel_t opnd_sel;
        logic      in_ready;
        logic      ld_offset;
        logic      ld_lbase;
        logic      ld_rbase;
        logic      ld_tz_byte;
        logic      ld_tz_bit;
        logic      fit_step;
        logic      clamp;
        logic      load_out;
    } ctrl_t;

    // Conditions from the datapath back to the sequencer.
    typedef struct packed {
        logic or_zero;
        logic align_gt_min;
        logic le;
        logic out_free;
    } status_t;

    // Mask of the lowest n bits; n of ADDR_W or more gives all ones.
    function automatic addr_t low_mask(input align_t n);
        addr_t m;
        for (int i = 0; i < ADDR_W; i++)
        begin
            m[i] = (ALIGN_W'(i) < n);
        end
        return m;
    endfunction

    // Trailing-zero count of one non-zero byte.
    function automatic bit_idx_t byte_tz(input logic [BYTE_W-1:0] v);
        bit_idx_t n;
        n = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                n = BIT_IDX_W'(i);
            end
        end
        return n;
    endfunction

endpackage

// ===== src/flexfit_top.sv =====
`timescale 1ns / 1ps
// Top level of the flexpage alignment fitter: request registers, datapath and output register.
//
// Usage: a request on the input channel (in_valid, in_ready, in_data) carries one fault
// address with the region's remote start, the local copy's start and end and the alignment
// limit. The result on the output channel (out_valid, out_ready, out_data) gives the chosen
// mapping alignment and the local and remote map bases rounded down to it.
// One request is in flight at a time: in_ready is high only while the sequencer is idle.
// out_valid rises once the sequencer has stepped through its offset, base, trailing-zero,
// fit, clamp and output states. Each alignment that the fit loop tries is tested against
// its lower bound and, only when that passes, against its upper bound; the worst case
// lowers a full-width alignment to one page with every lower bound passing. The sequencer
// is idle again in the cycle after the result is loaded; no new request is taken before the
// last one is through. The steps run in turn as the single 65-bit adder works out the page
// offset, both page bases and, one bound per cycle, the loop's lower and upper fit compares.
// The result sits in an output register. The next request is accepted as soon as the
// sequencer is back in idle, while the earlier result may still wait there; a finished
// result that finds the output register still full waits in the sequencer until the
// receiver takes the earlier one, so a stalled receiver holds off further requests.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and empties the
// output register; no request or result survives it.
module flexpage_alignment_fitter_top (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  flexfit_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output flexfit_pkg::out_item_t out_data
);

    flexfit_pkg::ctrl_t     ctrl;
    flexfit_pkg::status_t   status;

    // Request registers; these are payload and are loaded on acceptance.
    flexfit_pkg::addr_t     fault_reg;
    flexfit_pkg::addr_t     rstart_reg;
    flexfit_pkg::addr_t     lstart_reg;
    flexfit_pkg::addr_t     lend_reg;
    flexfit_pkg::align_t    limit_reg;

    // Working registers of the datapath.
    flexfit_pkg::addr_t     offset_reg;
    flexfit_pkg::addr_t     lbase_reg;
    flexfit_pkg::addr_t     rbase_reg;
    flexfit_pkg::byte_idx_t byte_idx_reg;
    flexfit_pkg::align_t    align_reg;
    flexfit_pkg::align_t    align_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    flexfit_pkg::out_item_t out_data_reg;

    flexfit_pkg::addr_t     alu_a;
    flexfit_pkg::addr_t     alu_b;
    flexfit_pkg::addr_t     alu_sum;
    logic                   alu_le;

    flexfit_pkg::addr_t     fit_mask;
    flexfit_pkg::addr_t     fit_blk;
    flexfit_pkg::addr_t     or_word;
    logic [flexfit_pkg::BYTE_CNT-1:0] byte_nz;
    flexfit_pkg::byte_idx_t low_byte;
    logic [flexfit_pkg::BYTE_W-1:0]   sel_byte;
    flexfit_pkg::addr_t     out_mask;

    assign in_ready  = ctrl.in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    flexfit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .ctrl     (ctrl)
    );

    flexfit_alu u_alu (
        .op  (ctrl.alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum),
        .le  (alu_le)
    );

    // The block being tested is the aligned local block that holds the local page.
    assign fit_mask = flexfit_pkg::low_mask(align_reg);
    assign fit_blk  = lbase_reg & ~fit_mask;

    // Operand selection for the shared adder. A compare asks whether a <= b.
    always_comb
    begin
        unique case (ctrl.opnd_sel)
            flexfit_pkg::SEL_OFFSET:
            begin
                alu_a = fault_reg;
                alu_b = rstart_reg;
            end
            flexfit_pkg::SEL_LBASE:
            begin
                alu_a = lstart_reg;
                alu_b = offset_reg;
            end
            flexfit_pkg::SEL_RBASE:
            begin
                alu_a = rstart_reg;
                alu_b = offset_reg;
            end
            flexfit_pkg::SEL_FIT_LO:
            begin
                alu_a = lstart_reg;
                alu_b = fit_blk;
            end
            flexfit_pkg::SEL_FIT_HI:
            begin
                alu_a = fit_blk | fit_mask;
                alu_b = lend_reg;
            end
            default:
            begin
                alu_a = fault_reg;
                alu_b = rstart_reg;
            end
        endcase
    end

    // The smaller trailing-zero count of the two bases is that of their OR. It is found in
    // two steps: first the lowest non-zero byte, then the lowest set bit inside it.
    assign or_word = lbase_reg | rbase_reg;

    always_comb
    begin
        for (int i = 0; i < flexfit_pkg::BYTE_CNT; i++)
        begin
            byte_nz[i] = |or_word[i*flexfit_pkg::BYTE_W +: flexfit_pkg::BYTE_W];
        end
    end

    always_comb
    begin
        low_byte = '0;
        for (int i = flexfit_pkg::BYTE_CNT - 1; i >= 0; i--)
        begin
            if (byte_nz[i])
            begin
                low_byte = flexfit_pkg::BYTE_IDX_W'(i);
            end
        end
    end

    assign sel_byte = or_word[byte_idx_reg*flexfit_pkg::BYTE_W +: flexfit_pkg::BYTE_W];

    assign status.or_zero      = ~|byte_nz;
    assign status.align_gt_min = (align_reg > flexfit_pkg::ALIGN_W'(flexfit_pkg::MIN_PAGE_SHIFT));
    assign status.le           = alu_le;
    assign status.out_free     = !out_valid_reg || out_ready;

    // The alignment register: set from the trailing-zero count, lowered by one on every
    // failed fit test, then clamped to the limit.
    always_comb
    begin
        align_next = align_reg;
        priority if (ctrl.ld_tz_byte && status.or_zero)
        begin
            align_next = flexfit_pkg::ALIGN_W'(flexfit_pkg::ADDR_W);
        end
        else if (ctrl.ld_tz_bit)
        begin
            align_next = flexfit_pkg::ALIGN_W'({byte_idx_reg, flexfit_pkg::byte_tz(sel_byte)});
        end
        else if (ctrl.fit_step && status.align_gt_min && !alu_le)
        begin
            align_next = align_reg - flexfit_pkg::ALIGN_W'(1);
        end
        else if (ctrl.clamp && (align_reg > limit_reg))
        begin
            align_next = limit_reg;
        end
        else
        begin
            align_next = align_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ctrl.in_ready)
        begin
            fault_reg  <= in_data.fault_address;
            rstart_reg <= in_data.remote_start;
            lstart_reg <= in_data.local_start;
            lend_reg   <= in_data.local_end;
            limit_reg  <= in_data.max_align;
        end
        if (ctrl.ld_offset)
        begin
            offset_reg <= alu_sum & ~flexfit_pkg::low_mask(
                              flexfit_pkg::ALIGN_W'(flexfit_pkg::MIN_PAGE_SHIFT));
        end
        if (ctrl.ld_lbase)
        begin
            lbase_reg <= alu_sum;
        end
        if (ctrl.ld_rbase)
        begin
            rbase_reg <= alu_sum;
        end
        if (ctrl.ld_tz_byte)
        begin
            byte_idx_reg <= low_byte;
        end
        align_reg <= align_next;
    end

    // Output register: loaded when the sequencer finishes and the slot is free.
    assign out_mask = flexfit_pkg::low_mask(align_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            out_data_reg.map_align       <= align_reg;
            out_data_reg.local_map_base  <= lbase_reg & ~out_mask;
            out_data_reg.remote_map_base <= rbase_reg & ~out_mask;
        end
    end

    always_comb
    begin
        priority if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // A request is never taken twice in a row: the sequencer leaves idle when it takes one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while the sequencer was busy");

    // A new result must never overwrite one that the receiver has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before it was taken");

    // The fit loop never works on an alignment wider than the address.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.fit_step |-> (align_reg <= flexfit_pkg::ALIGN_W'(flexfit_pkg::ADDR_W)))
        else $error("alignment out of range in the fit loop");

    // After clamping the alignment never exceeds the limit of the request.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clamp |=> (align_reg <= limit_reg))
        else $error("alignment above the limit after clamping");

endmodule

// ===== src/flexfit_alu.sv =====
`timescale 1ns / 1ps
// Shared adder unit: add, subtract and unsigned less-or-equal compare on addresses.
module flexfit_alu (
    input  flexfit_pkg::alu_op_t op,
    input  flexfit_pkg::addr_t   a,
    input  flexfit_pkg::addr_t   b,
    output flexfit_pkg::addr_t   sum,
    output logic                 le
);

    flexfit_pkg::addr_t          x;
    flexfit_pkg::addr_t          y;
    logic                        cin;
    logic [flexfit_pkg::ADDR_W:0] res;

    // The compare works out b - a; no borrow means a <= b.
    always_comb
    begin
        unique case (op)
            flexfit_pkg::ALU_ADD:
            begin
                x   = a;
                y   = b;
                cin = 1'b0;
            end
            flexfit_pkg::ALU_SUB:
            begin
                x   = a;
                y   = ~b;
                cin = 1'b1;
            end
            flexfit_pkg::ALU_LE:
            begin
                x   = b;
                y   = ~a;
                cin = 1'b1;
            end
            default:
            begin
                x   = a;
                y   = b;
                cin = 1'b0;
            end
        endcase
    end

    assign res = {1'b0, x} + {1'b0, y} + {{flexfit_pkg::ADDR_W{1'b0}}, cin};
    assign sum = res[flexfit_pkg::ADDR_W-1:0];
    assign le  = res[flexfit_pkg::ADDR_W];

endmodule

// ===== src/flexfit_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer that steps one request through the shared adder and the fit loop.
module flexfit_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  flexfit_pkg::status_t status,
    output flexfit_pkg::ctrl_t   ctrl
);

    flexfit_pkg::fsm_state_t state_reg;
    flexfit_pkg::fsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= flexfit_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            flexfit_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = flexfit_pkg::ST_OFFSET;
                end
            end
            flexfit_pkg::ST_OFFSET:  state_next = flexfit_pkg::ST_LBASE;
            flexfit_pkg::ST_LBASE:   state_next = flexfit_pkg::ST_RBASE;
            flexfit_pkg::ST_RBASE:   state_next = flexfit_pkg::ST_TZ_BYTE;
            flexfit_pkg::ST_TZ_BYTE:
            begin
                state_next = status.or_zero ? flexfit_pkg::ST_FIT_LO : flexfit_pkg::ST_TZ_BIT;
            end
            flexfit_pkg::ST_TZ_BIT:  state_next = flexfit_pkg::ST_FIT_LO;
            flexfit_pkg::ST_FIT_LO:
            begin
                priority if (!status.align_gt_min)
                begin
                    state_next = flexfit_pkg::ST_CLAMP;
                end
                else if (status.le)
                begin
                    state_next = flexfit_pkg::ST_FIT_HI;
                end
                else
                begin
                    state_next = flexfit_pkg::ST_FIT_LO;
                end
            end
            flexfit_pkg::ST_FIT_HI:
            begin
                state_next = status.le ? flexfit_pkg::ST_CLAMP : flexfit_pkg::ST_FIT_LO;
            end
            flexfit_pkg::ST_CLAMP:   state_next = flexfit_pkg::ST_OUTPUT;
            flexfit_pkg::ST_OUTPUT:
            begin
                if (status.out_free)
                begin
                    state_next = flexfit_pkg::ST_IDLE;
                end
            end
            default:                 state_next = flexfit_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl            = '0;
        ctrl.alu_op     = flexfit_pkg::ALU_ADD;
        ctrl.opnd_sel   = flexfit_pkg::SEL_OFFSET;
        unique case (state_reg)
            flexfit_pkg::ST_IDLE:    ctrl.in_ready = 1'b1;
            flexfit_pkg::ST_OFFSET:
            begin
                ctrl.alu_op    = flexfit_pkg::ALU_SUB;
                ctrl.opnd_sel  = flexfit_pkg::SEL_OFFSET;
                ctrl.ld_offset = 1'b1;
            end
            flexfit_pkg::ST_LBASE:
            begin
                ctrl.alu_op   = flexfit_pkg::ALU_ADD;
                ctrl.opnd_sel = flexfit_pkg::SEL_LBASE;
                ctrl.ld_lbase = 1'b1;
            end
            flexfit_pkg::ST_RBASE:
            begin
                ctrl.alu_op   = flexfit_pkg::ALU_ADD;
                ctrl.opnd_sel = flexfit_pkg::SEL_RBASE;
                ctrl.ld_rbase = 1'b1;
            end
            flexfit_pkg::ST_TZ_BYTE: ctrl.ld_tz_byte = 1'b1;
            flexfit_pkg::ST_TZ_BIT:  ctrl.ld_tz_bit = 1'b1;
            flexfit_pkg::ST_FIT_LO:
            begin
                ctrl.alu_op   = flexfit_pkg::ALU_LE;
                ctrl.opnd_sel = flexfit_pkg::SEL_FIT_LO;
                ctrl.fit_step = 1'b1;
            end
            flexfit_pkg::ST_FIT_HI:
            begin
                ctrl.alu_op   = flexfit_pkg::ALU_LE;
                ctrl.opnd_sel = flexfit_pkg::SEL_FIT_HI;
                ctrl.fit_step = 1'b1;
            end
            flexfit_pkg::ST_CLAMP:   ctrl.clamp = 1'b1;
            flexfit_pkg::ST_OUTPUT:  ctrl.load_out = status.out_free;
            default:                 ctrl.in_ready = 1'b0;
        endcase
    end

endmodule
